FILE: rtl/core/stat_pkg.sv
package stat_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int POWER_BITS  = 4;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = POWER_BITS + 32;

  localparam logic [2:0] ST_APPEND   = 3'd0;
  localparam logic [2:0] ST_INSERT   = 3'd1;
  localparam logic [2:0] ST_MERGE    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_READ_OK  = 3'd4;
  localparam logic [2:0] ST_READ_BAD = 3'd5;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic               op;
    logic [3:0]         power;
    logic [31:0]        exponent;
    logic signed [31:0] coeff;
    logic [5:0]         read_index;
  } term_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         position;
    logic [3:0]         entry_power;
    logic [31:0]        entry_exponent;
    logic signed [31:0] entry_coeff;
    logic               saturated;
    logic [6:0]         entry_count;
  } result_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic             cmp_en;
    logic [KEY_W-1:0] cmp_key;
    logic [IDX_W-1:0] rd_index;
    logic             ins_en;
    logic             merge_en;
    logic [KEY_W-1:0] ins_key;
    logic [31:0]      wcoeff;
  } cell_cmd_t;

  // what a cell hands to its upper neighbour
  typedef struct packed {
    logic             valid;
    logic             le;
    logic [KEY_W-1:0] key;
    logic [31:0]      coeff;
  } cell_link_t;

  typedef struct packed {
    logic eq;
    logic sel;
    logic bnd;
  } cell_tap_t;

endpackage

FILE: rtl/core/stat_cell.sv
module stat_cell import stat_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  cell_cmd_t        cmd,
  input  cell_link_t       prev,
  output cell_link_t       link,
  output cell_tap_t        tap
);

  logic             valid;
  logic             le;
  logic             eq;
  logic             sel;
  logic [KEY_W-1:0] key;
  logic [31:0]      coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      le    <= 1'b0;
      eq    <= 1'b0;
      sel   <= 1'b0;
    end else begin
      if (cmd.cmp_en) begin
        le  <= valid && (key <= cmd.cmp_key);
        eq  <= valid && (key == cmd.cmp_key);
        sel <= (idx == cmd.rd_index);
      end
      // the valid run grows by one from the bottom of the chain
      if (cmd.ins_en) begin
        valid <= valid | prev.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_en && !le) begin
      if (prev.le) begin
        key   <= cmd.ins_key;
        coeff <= cmd.wcoeff;
      end else begin
        // shift up: take the neighbour's entry
        key   <= prev.key;
        coeff <= prev.coeff;
      end
    end else if (cmd.merge_en && eq) begin
      coeff <= cmd.wcoeff;
    end
  end

  assign link.valid = valid;
  assign link.le    = le;
  assign link.key   = key;
  assign link.coeff = coeff;

  assign tap.eq  = eq;
  assign tap.sel = sel;
  assign tap.bnd = !le && prev.le;

endmodule

FILE: rtl/core/sorted_term_accumulate_table_unit.sv
// Sorted term table: keeps up to TABLE_DEPTH terms ordered by power, then
// exponent, one coefficient per key, in a chain of cells.
// Request channel (term_valid / term_ready / term): op add merges the
// coefficient into a matching entry with saturation, or inserts a new
// entry at its sorted place; op read returns the entry at read_index.
// Result channel (result_valid / result_ready / result): one result per
// request, holding status, position, the entry afterwards and the count.
// Timing: a request is compared in every cell at the edge it is accepted;
// then, once the output register is free, the selected entry is combined,
// the chain shifts or merges and the result is registered. A new request
// is not taken until the previous one has finished its compare-then-update
// pass through the chain.
// A finished result waits in the output register while the next request
// is accepted and compared; that request then holds in its update step
// until the result is taken, so a stalled receiver stalls the sender.
// Reset empties the table (entry count zero) and clears both valids.
module sorted_term_accumulate_table_unit import stat_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    term_valid,
  output logic    term_ready,
  input  term_t   term,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic             busy;
  term_t            req;
  logic [CNT_W-1:0] count;
  logic             fire;
  logic             full;
  logic             hit;
  logic [31:0]      old_coeff;
  logic [IDX_W-1:0] mpos;
  logic [IDX_W-1:0] ipos;
  logic [KEY_W-1:0] rkey;
  logic [31:0]      rcoeff;
  logic signed [32:0] sum;
  logic [31:0]      sat_sum;
  logic             sat;
  logic             rd_ok;
  result_t          result_next;
  cell_cmd_t        cmd;
  cell_link_t       links [TABLE_DEPTH];
  cell_link_t       prevs [TABLE_DEPTH];
  cell_tap_t        taps  [TABLE_DEPTH];

  assign term_ready = !busy;
  assign fire = busy && (!result_valid || result_ready);
  assign full = (count == CNT_W'(TABLE_DEPTH));

  // bottom of the chain sees an always-valid, always-lower neighbour
  assign prevs[0] = '{valid: 1'b1, le: 1'b1, key: '0, coeff: '0};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i > 0) begin : g_prev
      assign prevs[i] = links[i-1];
    end
    stat_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .idx  (IDX_W'(i)),
      .cmd  (cmd),
      .prev (prevs[i]),
      .link (links[i]),
      .tap  (taps[i])
    );
  end

  // one-hot selection over the chain
  always_comb begin
    hit       = 1'b0;
    old_coeff = '0;
    mpos      = '0;
    ipos      = '0;
    rkey      = '0;
    rcoeff    = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit       = hit | taps[i].eq;
      old_coeff = old_coeff | ({32{taps[i].eq}} & links[i].coeff);
      mpos      = mpos | ({IDX_W{taps[i].eq}} & IDX_W'(i));
      ipos      = ipos | ({IDX_W{taps[i].bnd}} & IDX_W'(i));
      rkey      = rkey | ({KEY_W{taps[i].sel}} & links[i].key);
      rcoeff    = rcoeff | ({32{taps[i].sel}} & links[i].coeff);
    end
  end

  always_comb begin
    sum = {old_coeff[31], old_coeff} + {req.coeff[31], req.coeff};
    sat = (sum[32] != sum[31]);
    if (!sat) begin
      sat_sum = sum[31:0];
    end else if (sum[32]) begin
      sat_sum = 32'h8000_0000;
    end else begin
      sat_sum = 32'h7FFF_FFFF;
    end
  end

  always_comb begin
    cmd.cmp_en   = term_valid && term_ready;
    cmd.cmp_key  = {term.power[POWER_BITS-1:0], term.exponent};
    cmd.rd_index = IDX_W'(term.read_index);
    cmd.ins_en   = fire && (req.op == OP_ADD) && !hit && !full;
    cmd.merge_en = fire && (req.op == OP_ADD) && hit;
    cmd.ins_key  = {req.power[POWER_BITS-1:0], req.exponent};
    cmd.wcoeff   = hit ? sat_sum : req.coeff;
  end

  assign rd_ok = (CNT_W'(req.read_index) < count);

  always_comb begin
    result_next             = '0;
    result_next.entry_count = 7'(count);
    if (req.op == OP_READ) begin
      result_next.position = req.read_index;
      if (rd_ok) begin
        result_next.status         = ST_READ_OK;
        result_next.entry_power    = 4'(rkey[KEY_W-1:32]);
        result_next.entry_exponent = rkey[31:0];
        result_next.entry_coeff    = rcoeff;
      end else begin
        result_next.status = ST_READ_BAD;
      end
    end else if (hit) begin
      result_next.status         = ST_MERGE;
      result_next.position       = 6'(mpos);
      result_next.entry_power    = 4'(req.power[POWER_BITS-1:0]);
      result_next.entry_exponent = req.exponent;
      result_next.entry_coeff    = sat_sum;
      result_next.saturated      = sat;
    end else if (full) begin
      result_next.status = ST_FULL;
    end else begin
      result_next.status         = (CNT_W'(ipos) == count) ? ST_APPEND : ST_INSERT;
      result_next.position       = 6'(ipos);
      result_next.entry_power    = 4'(req.power[POWER_BITS-1:0]);
      result_next.entry_exponent = req.exponent;
      result_next.entry_coeff    = req.coeff;
      result_next.entry_count    = 7'(count + CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (term_valid && term_ready) begin
        busy <= 1'b1;
      end else if (fire) begin
        busy <= 1'b0;
      end
      if (cmd.ins_en) begin
        count <= count + CNT_W'(1);
      end
      if (fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (term_valid && term_ready) begin
      req <= term;
    end
    if (fire) begin
      result <= result_next;
    end
  end

endmodule

FILE: tb/sv/term_table_check_pkg.sv
package term_table_check_pkg;
  import stat_pkg::*;

  class sorted_table_checker;
    logic [KEY_W-1:0]   keys [TABLE_DEPTH];
    logic signed [31:0] coeffs [TABLE_DEPTH];
    int                 fill;
    result_t            expected_results[$];
    int                 mismatches;
    int                 results_seen;
    int                 status_hits[6];
    int                 clamps;

    function new();
      fill = 0;
      mismatches = 0;
      results_seen = 0;
      clamps = 0;
      foreach (status_hits[s]) status_hits[s] = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // work out the result of one accepted request and update the table copy
    function void note_request(term_t t);
      result_t            r;
      logic [KEY_W-1:0]   k;
      longint             sum;
      int                 ub;
      int                 idx;
      int                 i;
      r = '0;
      if (t.op == OP_READ) begin
        idx = t.read_index;
        r.position = t.read_index;
        if (idx < fill) begin
          r.status         = ST_READ_OK;
          r.entry_power    = keys[idx][KEY_W-1:32];
          r.entry_exponent = keys[idx][31:0];
          r.entry_coeff    = coeffs[idx];
        end else begin
          r.status = ST_READ_BAD;
        end
      end else begin
        k = {t.power[POWER_BITS-1:0], t.exponent};
        ub = 0;
        while (ub < fill && keys[ub] <= k) ub++;
        if (ub > 0 && keys[ub-1] == k) begin
          sum = longint'(coeffs[ub-1]) + longint'($signed(t.coeff));
          if (sum > longint'(32'sh7fffffff)) begin
            sum = 32'sh7fffffff;
            r.saturated = 1'b1;
          end else if (sum < -longint'(64'h80000000)) begin
            sum = -longint'(64'h80000000);
            r.saturated = 1'b1;
          end
          coeffs[ub-1]     = sum[31:0];
          r.status         = ST_MERGE;
          r.position       = 6'(ub - 1);
          r.entry_power    = keys[ub-1][KEY_W-1:32];
          r.entry_exponent = keys[ub-1][31:0];
          r.entry_coeff    = coeffs[ub-1];
        end else if (fill >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = fill; i > ub; i--) begin
            keys[i]   = keys[i-1];
            coeffs[i] = coeffs[i-1];
          end
          keys[ub]         = k;
          coeffs[ub]       = $signed(t.coeff);
          r.status         = (ub == fill) ? ST_APPEND : ST_INSERT;
          fill++;
          r.position       = 6'(ub);
          r.entry_power    = keys[ub][KEY_W-1:32];
          r.entry_exponent = keys[ub][31:0];
          r.entry_coeff    = coeffs[ub];
        end
      end
      r.entry_count = 7'(fill);
      status_hits[r.status]++;
      if (r.saturated) clamps++;
      expected_results.insert(expected_results.size(), r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch at result %0d, %s: got %h, want %h", results_seen, what, got,
                 want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report("result with no request waiting", 32'(got.status), 32'(0));
        results_seen++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report("status", 32'(got.status), 32'(want.status));
      if (got.position !== want.position)
        report("position", 32'(got.position), 32'(want.position));
      if (got.entry_power !== want.entry_power)
        report("entry_power", 32'(got.entry_power), 32'(want.entry_power));
      if (got.entry_exponent !== want.entry_exponent)
        report("entry_exponent", got.entry_exponent, want.entry_exponent);
      if (got.entry_coeff !== want.entry_coeff)
        report("entry_coeff", got.entry_coeff, want.entry_coeff);
      if (got.saturated !== want.saturated)
        report("saturated", 32'(got.saturated), 32'(want.saturated));
      if (got.entry_count !== want.entry_count)
        report("entry_count", 32'(got.entry_count), 32'(want.entry_count));
      results_seen++;
    endtask
  endclass

endpackage

FILE: tb/sv/tb_top.sv
module tb_top;
  import stat_pkg::*;
  import term_table_check_pkg::*;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int POOL_SIZE   = 100;
  localparam int RANDOM_ITEMS = 1000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    term_valid = 1'b0;
  logic    term_ready;
  term_t   term = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  sorted_table_checker table_check = new();

  idle_mode_e  idle_mode = IDLE_NONE;
  int          hold_req_n = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          cycle_count = 0;
  int          random_sent = 0;
  logic [3:0]  pool_power [POOL_SIZE];
  logic [31:0] pool_exp [POOL_SIZE];

  sorted_term_accumulate_table_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .term_valid   (term_valid),
    .term_ready   (term_ready),
    .term         (term),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               table_check.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) table_check.check_result(result);
      if (term_valid && term_ready) table_check.note_request(term);
    end
  end

  // receiver: a long hold-off when asked, otherwise stall per idling mode
  always @(negedge clk) begin
    if (hold_req_n != hold_seen) begin
      hold_seen = hold_req_n;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECV: result_ready <= ($urandom_range(0, 99) >= 51);
        IDLE_BOTH: result_ready <= ($urandom_range(0, 99) >= 15);
        default:   result_ready <= 1'b1;
      endcase
    end
  end

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 51;
      IDLE_BOTH: return $urandom_range(0, 99) < 15;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic term_t make_term(logic op, logic [3:0] power, logic [31:0] exponent,
                                      logic [31:0] coeff, logic [5:0] read_index);
    term_t t;
    t.op = op;
    t.power = power;
    t.exponent = exponent;
    t.coeff = coeff;
    t.read_index = read_index;
    return t;
  endfunction

  // keys come from a pool that widens over the run, so the table fills gradually
  function automatic term_t random_request();
    term_t t;
    int    active;
    int    slot;
    active = 4 + (random_sent * (POOL_SIZE - 4)) / RANDOM_ITEMS;
    if (active > POOL_SIZE) active = POOL_SIZE;
    slot = $urandom_range(0, active - 1);
    t.op = ($urandom_range(0, 3) == 0) ? OP_READ : OP_ADD;
    t.power = pool_power[slot];
    t.exponent = pool_exp[slot];
    if (t.op == OP_READ || $urandom_range(0, 9) == 0) begin
      t.power = 4'($urandom);
      t.exponent = $urandom;
    end
    case ($urandom_range(0, 3))
      0: t.coeff = $urandom;
      1: t.coeff = 32'h7fffffff - $urandom_range(0, 255);
      2: t.coeff = 32'h80000000 + $urandom_range(0, 255);
      default: t.coeff = $urandom_range(0, 511) - 256;
    endcase
    t.read_index = 6'($urandom_range(0, 63));
    return t;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_term(term_t t);
    while (sender_gap()) begin
      term_valid <= 1'b0;
      @(negedge clk);
    end
    term_valid <= 1'b1;
    term <= t;
    do @(posedge clk); while (!term_ready);
    @(negedge clk);
  endtask

  task automatic wait_table_idle();
    term_valid <= 1'b0;
    while (table_check.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(idle_mode_e m, int count);
    idle_mode = m;
    repeat (count) begin
      send_term(random_request());
      random_sent++;
    end
  endtask

  initial begin
    int          j;
    logic [3:0]  sp;
    logic [31:0] se;
    logic [31:0] common_exp [4];
    common_exp[0] = 32'h0;
    common_exp[1] = 32'h8000;
    common_exp[2] = 32'h10000;
    common_exp[3] = 32'hffffffff;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_power[i] = 4'(i % 16);
      pool_exp[i] = (i < 64) ? common_exp[i / 16] : $urandom;
    end
    for (int i = POOL_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      sp = pool_power[i];
      se = pool_exp[i];
      pool_power[i] = pool_power[j];
      pool_exp[i] = pool_exp[j];
      pool_power[j] = sp;
      pool_exp[j] = se;
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty reads, appends, front and middle inserts, clamping in both directions
    send_term(make_term(OP_READ, 4'd0, 32'h0, 32'h0, 6'd0));
    send_term(make_term(OP_READ, 4'd0, 32'h0, 32'h0, 6'd63));
    send_term(make_term(OP_ADD, 4'd5, 32'h10000, 32'h01000000, 6'd0));
    send_term(make_term(OP_ADD, 4'd5, 32'h8000, 32'hffffff00, 6'd63));
    send_term(make_term(OP_ADD, 4'd15, 32'hffffffff, 32'h7fffffff, 6'd0));
    send_term(make_term(OP_ADD, 4'd0, 32'h0, 32'h80000000, 6'd0));
    send_term(make_term(OP_ADD, 4'd5, 32'h10000, 32'h7f000000, 6'd0));
    send_term(make_term(OP_ADD, 4'd0, 32'h0, 32'hffffffff, 6'd0));
    send_term(make_term(OP_ADD, 4'd15, 32'hffffffff, 32'h1, 6'd0));
    send_term(make_term(OP_ADD, 4'd5, 32'h8000, 32'h0, 6'd0));
    send_term(make_term(OP_ADD, 4'd7, 32'h12345678, 32'h00c0ffee, 6'd0));
    send_term(make_term(OP_ADD, 4'd7, 32'h12345678, 32'hff3f0012, 6'd0));
    send_term(make_term(OP_ADD, 4'd15, 32'h0, 32'h12345678, 6'd0));
    send_term(make_term(OP_ADD, 4'd0, 32'h1, 32'hedcba987, 6'd42));
    send_term(make_term(OP_READ, 4'd0, 32'h0, 32'h0, 6'd0));
    send_term(make_term(OP_READ, 4'd15, 32'hffffffff, 32'hffffffff, 6'd6));
    send_term(make_term(OP_READ, 4'd0, 32'h0, 32'h0, 6'd7));
    send_term(make_term(OP_READ, 4'd15, 32'hffffffff, 32'h80000000, 6'd63));

    run_phase(IDLE_NONE, 150);

    // hold results off while requests keep coming, then pause until drained
    hold_req_n++;
    run_phase(IDLE_NONE, 30);
    wait_table_idle();

    run_phase(IDLE_SEND, 270);
    run_phase(IDLE_RECV, 270);
    run_phase(IDLE_BOTH, 270);
    run_phase(IDLE_NONE, 10);

    idle_mode = IDLE_NONE;
    wait_table_idle();
    repeat (8) @(negedge clk);

    $display("Checked %0d results over four idling modes, a long result hold-off and drains.",
             table_check.results_seen);
    $display("Appended %0d, inserted %0d, merged %0d (%0d clamped), dropped %0d, reads %0d/%0d",
             table_check.status_hits[ST_APPEND], table_check.status_hits[ST_INSERT],
             table_check.status_hits[ST_MERGE], table_check.clamps,
             table_check.status_hits[ST_FULL], table_check.status_hits[ST_READ_OK],
             table_check.status_hits[ST_READ_BAD]);
    if (table_check.mismatches == 0 && table_check.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/stat_pkg.sv
rtl/core/stat_cell.sv
rtl/core/sorted_term_accumulate_table_unit.sv
tb/sv/term_table_check_pkg.sv
tb/sv/tb_top.sv
